@@ design/i2cm_pkg.sv @@
// ----------------------------------------------------------------------------
// i2cm_pkg
// Shared types, codes and segment tables of the I2C register access master.
// ----------------------------------------------------------------------------
`default_nettype none

package i2cm_pkg;

	localparam int unsigned CMD_W      = 3;
	localparam int unsigned BYTE_W     = 8;
	localparam int unsigned DEV_W      = 7;
	localparam int unsigned PHASE_W    = 6;
	localparam int unsigned SEG_IDX_W  = 3;
	localparam int unsigned CFG_IDX_W  = 1;
	localparam int unsigned CFG_DATA_W = DEV_W;

	localparam logic [PHASE_W-1:0] PHASE_IDLE = 6'd63;

	localparam logic [DEV_W-1:0] RTC_DEV_RESET = 7'd104;
	localparam logic [DEV_W-1:0] MEM_DEV_RESET = 7'd80;

	localparam logic [PHASE_W-1:0] LEN_START = 6'd5;
	localparam logic [PHASE_W-1:0] LEN_SEND  = 6'd27;
	localparam logic [PHASE_W-1:0] LEN_READ  = 6'd21;
	localparam logic [PHASE_W-1:0] LEN_STOP  = 6'd4;
	localparam logic [PHASE_W-1:0] LEN_END   = 6'd1;

	localparam logic [PHASE_W-1:0] SEND_ACK_SETUP = 6'd24;
	localparam logic [PHASE_W-1:0] SEND_ACK_HIGH  = 6'd25;
	localparam logic [PHASE_W-1:0] READ_BITS_LAST = 6'd16;
	localparam logic [PHASE_W-1:0] READ_NACK      = 6'd17;
	localparam logic [PHASE_W-1:0] READ_NACK_HIGH = 6'd18;
	localparam logic [PHASE_W-1:0] READ_NACK_LOW  = 6'd19;

	typedef enum logic [CMD_W-1:0] {
		CMD_TICK   = 3'd0,
		CMD_REG_WR = 3'd1,
		CMD_REG_RD = 3'd2,
		CMD_MEM_WR = 3'd3,
		CMD_MEM_RD = 3'd4
	} cmd_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_RTC_DEV = 1'b0,
		CFG_MEM_DEV = 1'b1
	} cfg_idx_t;

	typedef enum logic [2:0] {
		SEG_END   = 3'd0,
		SEG_START = 3'd1,
		SEG_SEND  = 3'd2,
		SEG_READ  = 3'd3,
		SEG_STOP  = 3'd4
	} seg_kind_t;

	typedef enum logic [2:0] {
		SEL_NONE  = 3'd0,
		SEL_DEV_W = 3'd1,
		SEL_DEV_R = 3'd2,
		SEL_ADDR  = 3'd3,
		SEL_DATA  = 3'd4,
		SEL_ZERO  = 3'd5
	} byte_sel_t;

	localparam seg_kind_t SEG_KIND_TAB [0:3][0:7] = '{
		'{SEG_START, SEG_SEND, SEG_SEND, SEG_SEND, SEG_STOP, SEG_END, SEG_END, SEG_END},
		'{SEG_START, SEG_SEND, SEG_SEND, SEG_START, SEG_SEND, SEG_READ, SEG_STOP, SEG_END},
		'{SEG_START, SEG_SEND, SEG_SEND, SEG_SEND, SEG_SEND, SEG_STOP, SEG_END, SEG_END},
		'{SEG_START, SEG_SEND, SEG_SEND, SEG_SEND, SEG_START, SEG_SEND, SEG_READ, SEG_STOP}
	};

	localparam byte_sel_t SEG_BYTE_TAB [0:3][0:7] = '{
		'{SEL_NONE, SEL_DEV_W, SEL_ADDR, SEL_DATA, SEL_NONE, SEL_NONE, SEL_NONE, SEL_NONE},
		'{SEL_NONE, SEL_DEV_W, SEL_ADDR, SEL_NONE, SEL_DEV_R, SEL_NONE, SEL_NONE, SEL_NONE},
		'{SEL_NONE, SEL_DEV_W, SEL_ZERO, SEL_ADDR, SEL_DATA, SEL_NONE, SEL_NONE, SEL_NONE},
		'{SEL_NONE, SEL_DEV_W, SEL_ZERO, SEL_ADDR, SEL_NONE, SEL_DEV_R, SEL_NONE, SEL_NONE}
	};

	typedef struct packed {
		logic [PHASE_W-1:0]   phase;
		logic [1:0]           sub;
		logic [BYTE_W-1:0]    shreg;
		logic [SEG_IDX_W-1:0] seg_idx;
		logic [CMD_W-1:0]     lcmd;
		logic [BYTE_W-1:0]    laddr;
		logic [BYTE_W-1:0]    lwdata;
		logic [BYTE_W-1:0]    rxbyte;
		logic                 ackerr;
		logic                 scl;
		logic                 sda;
		logic                 drv;
	} seq_state_t;

	typedef struct packed {
		logic              scl_level;
		logic              sda_level;
		logic              sda_drive;
		logic              busy_res;
		logic              done_res;
		logic [BYTE_W-1:0] read_data;
		logic              ack_error;
	} step_res_t;

	function automatic logic [PHASE_W-1:0] seg_len(seg_kind_t kind);
		case (kind)
			SEG_START: return LEN_START;
			SEG_SEND:  return LEN_SEND;
			SEG_READ:  return LEN_READ;
			SEG_STOP:  return LEN_STOP;
			default:   return LEN_END;
		endcase
	endfunction

endpackage

`default_nettype wire

@@ design/i2cm_item_if.sv @@
// ----------------------------------------------------------------------------
// i2cm_item_if
// Input channel: one tick with an optional command and the sampled SDA level.
// ----------------------------------------------------------------------------
`default_nettype none

interface i2cm_item_if;
	logic       valid;
	logic       ready;
	logic [2:0] cmd;
	logic [7:0] reg_address;
	logic [7:0] write_data;
	logic       sda_in;

	modport source (output valid, cmd, reg_address, write_data, sda_in, input ready);
	modport sink   (input valid, cmd, reg_address, write_data, sda_in, output ready);
endinterface

`default_nettype wire

@@ design/i2cm_result_if.sv @@
// ----------------------------------------------------------------------------
// i2cm_result_if
// Result channel: pin levels and transaction status after one tick.
// ----------------------------------------------------------------------------
`default_nettype none

interface i2cm_result_if;
	logic       valid;
	logic       ready;
	logic       scl_level;
	logic       sda_level;
	logic       sda_drive;
	logic       busy_res;
	logic       done_res;
	logic [7:0] read_data;
	logic       ack_error;

	modport source (output valid, scl_level, sda_level, sda_drive, busy_res, done_res,
		read_data, ack_error, input ready);
	modport sink   (input valid, scl_level, sda_level, sda_drive, busy_res, done_res,
		read_data, ack_error, output ready);
endinterface

`default_nettype wire

@@ design/i2cm_step.sv @@
// ----------------------------------------------------------------------------
// i2cm_step
// One bus step: command latch, segment decode, pin update and next phase.
// ----------------------------------------------------------------------------
`default_nettype none

module i2cm_step
	import i2cm_pkg::*;
(
	input  seq_state_t        st,
	input  logic [CMD_W-1:0]  cmd,
	input  logic [BYTE_W-1:0] reg_address,
	input  logic [BYTE_W-1:0] write_data,
	input  logic              sda_in,
	input  logic [DEV_W-1:0]  rtc_dev,
	input  logic [DEV_W-1:0]  mem_dev,
	output seq_state_t        st_nxt,
	output step_res_t         res
);

	seq_state_t         n;
	logic               busy;
	logic               done;
	logic               last;
	logic [1:0]         row;
	seg_kind_t          kind;
	byte_sel_t          sel;
	logic [PHASE_W-1:0] p;
	logic [PHASE_W-1:0] pn;
	logic [1:0]         sub;
	logic [BYTE_W-1:0]  sh;
	logic [DEV_W-1:0]   dev;
	logic               is_mem;

	always_comb begin
		n    = st;
		busy = 1'b0;
		done = 1'b0;
		last = 1'b0;
		sub  = 2'd0;
		sh   = '0;
		pn   = '0;

		if (st.phase == PHASE_IDLE && cmd >= CMD_REG_WR && cmd <= CMD_MEM_RD) begin
			n.lcmd    = cmd;
			n.laddr   = reg_address;
			n.lwdata  = write_data;
			n.ackerr  = 1'b0;
			n.seg_idx = '0;
			n.phase   = '0;
		end

		row    = n.lcmd[1:0] - 2'd1;
		kind   = SEG_KIND_TAB[row][n.seg_idx];
		sel    = SEG_BYTE_TAB[row][n.seg_idx];
		p      = n.phase;
		is_mem = (n.lcmd == CMD_MEM_WR) || (n.lcmd == CMD_MEM_RD);
		dev    = is_mem ? mem_dev : rtc_dev;

		if (n.phase != PHASE_IDLE) begin
			busy = 1'b1;
			unique case (kind)
				SEG_START: begin
					case (p)
						6'd0: begin
							n.drv = 1'b1;
							n.scl = 1'b0;
						end
						6'd1: n.sda = 1'b1;
						6'd2: n.scl = 1'b1;
						6'd3: n.sda = 1'b0;
						default: n.scl = 1'b0;
					endcase
				end
				SEG_SEND: begin
					sub = (p == '0) ? 2'd0 : n.sub;
					sh  = n.shreg;
					if (p == '0) begin
						case (sel)
							SEL_DEV_W: sh = {dev, 1'b0};
							SEL_DEV_R: sh = {dev, 1'b1};
							SEL_ADDR:  sh = n.laddr;
							SEL_DATA:  sh = n.lwdata;
							default:   sh = '0;
						endcase
					end
					if (p < SEND_ACK_SETUP) begin
						case (sub)
							2'd0: begin
								n.drv = 1'b1;
								n.sda = sh[BYTE_W-1];
							end
							2'd1: n.scl = 1'b1;
							default: begin
								n.scl = 1'b0;
								sh    = {sh[BYTE_W-2:0], 1'b0};
							end
						endcase
						n.sub = (sub == 2'd2) ? 2'd0 : sub + 2'd1;
					end else if (p == SEND_ACK_SETUP) begin
						n.drv = 1'b1;
						n.sda = 1'b1;
					end else if (p == SEND_ACK_HIGH) begin
						n.drv = 1'b0;
						n.sda = 1'b1;
						n.scl = 1'b1;
					end else begin
						if (sda_in)
							n.ackerr = 1'b1;
						n.scl = 1'b0;
						n.drv = 1'b1;
						n.sda = 1'b1;
					end
					n.shreg = sh;
				end
				SEG_READ: begin
					if (p == '0) begin
						n.drv   = 1'b1;
						n.sda   = 1'b1;
						n.shreg = '0;
					end else if (p <= READ_BITS_LAST) begin
						if (p[0]) begin
							n.drv = 1'b0;
							n.sda = 1'b1;
							n.scl = 1'b1;
						end else begin
							n.shreg = {n.shreg[BYTE_W-2:0], sda_in};
							n.scl   = 1'b0;
						end
					end else if (p == READ_NACK) begin
						n.drv    = 1'b1;
						n.sda    = 1'b1;
						n.rxbyte = n.shreg;
					end else if (p == READ_NACK_HIGH) begin
						n.scl = 1'b1;
					end else if (p == READ_NACK_LOW) begin
						n.scl = 1'b0;
					end else begin
						n.sda = 1'b1;
					end
				end
				SEG_STOP: begin
					n.drv = 1'b1;
					case (p)
						6'd0: n.sda = 1'b0;
						6'd1: n.scl = 1'b1;
						6'd2: n.sda = 1'b1;
						default: begin
							n.scl = 1'b0;
							last  = 1'b1;
						end
					endcase
				end
				default: last = 1'b1;
			endcase

			if (last) begin
				n.phase   = PHASE_IDLE;
				n.seg_idx = '0;
				done      = 1'b1;
			end else begin
				pn = p + 6'd1;
				if (pn >= seg_len(kind)) begin
					n.phase   = '0;
					n.seg_idx = n.seg_idx + 3'd1;
				end else begin
					n.phase = pn;
				end
			end
		end
	end

	assign st_nxt = n;

	always_comb begin
		res.scl_level = n.scl;
		res.sda_level = n.sda;
		res.sda_drive = n.drv;
		res.busy_res  = busy;
		res.done_res  = done;
		res.read_data = n.rxbyte;
		res.ack_error = n.ackerr;
	end

endmodule

`default_nettype wire

@@ design/i2c_master_register_access_unit.sv @@
// ----------------------------------------------------------------------------
// i2c_master_register_access_unit
// Tick-stepped I2C master running register and memory byte transactions.
// ----------------------------------------------------------------------------
//  channel   dir  handshake     beat contents
//  item      in   valid/ready   cmd, reg_address, write_data, sda_in
//  result    out  valid/ready   scl_level, sda_level, sda_drive, busy_res,
//                               done_res, read_data, ack_error
//  cfg       in   cfg_we        cfg_index, cfg_data (device addresses)
//
//  One beat per cycle while result is ready; a beat's result is valid once
//  it passes the input register, then step logic into the result register.
//  The bus sequencer state advances once per beat, when the input register
//  moves into the result register.
//  Reset: idle, SCL and SDA high and driven, device addresses 104 and 80.
//  A stalled result holds the pipeline; item ready drops only when both
//  the input register and the result register are full.
// ----------------------------------------------------------------------------
`default_nettype none

module i2c_master_register_access_unit
	import i2cm_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	i2cm_item_if.sink             item,
	i2cm_result_if.source         result
);

	logic              valid_s1;
	logic [CMD_W-1:0]  cmd_s1;
	logic [BYTE_W-1:0] addr_s1;
	logic [BYTE_W-1:0] wdata_s1;
	logic              sda_s1;

	logic              out_valid_q;
	step_res_t         res_q;

	seq_state_t        st_q;
	seq_state_t        st_nxt;
	step_res_t         res_nxt;

	logic [DEV_W-1:0]  rtc_dev_q;
	logic [DEV_W-1:0]  mem_dev_q;

	logic              advance;
	logic              item_take;

	assign advance   = valid_s1 && (!out_valid_q || result.ready);
	assign item.ready = !valid_s1 || advance;
	assign item_take = item.valid && item.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (item_take) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (item_take) begin
			cmd_s1   <= item.cmd;
			addr_s1  <= item.reg_address;
			wdata_s1 <= item.write_data;
			sda_s1   <= item.sda_in;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rtc_dev_q <= RTC_DEV_RESET;
			mem_dev_q <= MEM_DEV_RESET;
		end else if (cfg_we) begin
			unique case (cfg_idx_t'(cfg_index))
				CFG_RTC_DEV: rtc_dev_q <= cfg_data;
				CFG_MEM_DEV: mem_dev_q <= cfg_data;
			endcase
		end
	end

	i2cm_step u_step (
		.st          (st_q),
		.cmd         (cmd_s1),
		.reg_address (addr_s1),
		.write_data  (wdata_s1),
		.sda_in      (sda_s1),
		.rtc_dev     (rtc_dev_q),
		.mem_dev     (mem_dev_q),
		.st_nxt      (st_nxt),
		.res         (res_nxt)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= '{
				phase:   PHASE_IDLE,
				sub:     2'd0,
				shreg:   '0,
				seg_idx: '0,
				lcmd:    '0,
				laddr:   '0,
				lwdata:  '0,
				rxbyte:  '0,
				ackerr:  1'b0,
				scl:     1'b1,
				sda:     1'b1,
				drv:     1'b1
			};
		end else if (advance) begin
			st_q <= st_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance)
			res_q <= res_nxt;
	end

	assign result.valid     = out_valid_q;
	assign result.scl_level = res_q.scl_level;
	assign result.sda_level = res_q.sda_level;
	assign result.sda_drive = res_q.sda_drive;
	assign result.busy_res  = res_q.busy_res;
	assign result.done_res  = res_q.done_res;
	assign result.read_data = res_q.read_data;
	assign result.ack_error = res_q.ack_error;

`ifndef SYNTHESIS
	a_done_busy: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && res_q.done_res |-> res_q.busy_res)
		else $error("done without busy");

	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		advance && res_nxt.done_res |=> st_q.phase == PHASE_IDLE)
		else $error("sequencer not idle after stop");

	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && out_valid_q && !result.ready |=> valid_s1 && $stable(st_q))
		else $error("sequencer moved while result stalled");
`endif

endmodule

`default_nettype wire
